### design/xxh_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers of the xxHash32 stream hasher.
// No dependencies; used by the controller, the datapath and the top level.
package xxh_pkg;

  localparam logic [31:0] PRIME1 = 32'h9E37_79B1;
  localparam logic [31:0] PRIME2 = 32'h85EB_CA77;
  localparam logic [31:0] PRIME3 = 32'hC2B2_AE3D;
  localparam logic [31:0] PRIME4 = 32'h27D4_EB2F;
  localparam logic [31:0] PRIME5 = 32'h1656_67B1;

  localparam int unsigned STRIPE_BYTES = 16;
  localparam int unsigned LANES        = 4;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_R_MUL,
    ST_R_ROT,
    ST_R_FIN,
    ST_MERGE0,
    ST_MERGE,
    ST_ADD_LEN,
    ST_TAIL,
    ST_W_MUL,
    ST_W_ROT,
    ST_W_FIN,
    ST_B_MUL,
    ST_B_ROT,
    ST_B_FIN,
    ST_AV1,
    ST_AV2,
    ST_EMIT
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_R_MUL,
    OP_R_ROT,
    OP_R_FIN,
    OP_MERGE_FIRST,
    OP_MERGE_ADD,
    OP_ADD_LEN,
    OP_W_MUL,
    OP_W_ROT,
    OP_W_FIN,
    OP_B_MUL,
    OP_B_ROT,
    OP_B_FIN,
    OP_AV1,
    OP_AV2,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] merge_lane;
  } cmd_t;

  typedef struct packed {
    logic stripe_edge; // next byte completes the 16-byte stripe
    logic seen;        // a full stripe went through the lanes
    logic fill_ge4;    // a whole word is left in the tail
    logic fill_nz;     // anything is left in the tail
    logic out_free;    // result register can take a digest
  } sts_t;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned r);
    return (x << r) | (x >> (32 - r));
  endfunction

endpackage

### design/xxh_msg_if.sv
`timescale 1ns / 1ps
// Message byte channel: valid/ready handshake with at most one byte per item.
// No dependencies.
interface xxh_msg_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       byte_present;
  logic       last;

  modport source (output valid, output byte_value, output byte_present, output last,
                  input ready);
  modport sink   (input valid, input byte_value, input byte_present, input last,
                  output ready);
endinterface

### design/xxh_digest_if.sv
`timescale 1ns / 1ps
// Digest channel: valid/ready handshake carrying hash and message length.
// No dependencies.
interface xxh_digest_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash_value;
  logic [31:0] message_length;

  modport source (output valid, output hash_value, output message_length, input ready);
  modport sink   (input valid, input hash_value, input message_length, output ready);
endinterface

### design/xxh_cfg_if.sv
`timescale 1ns / 1ps
// Configuration write channel for the seed register.
// No dependencies.
interface xxh_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] seed;

  modport source (output valid, output seed, input ready);
  modport sink   (input valid, input seed, output ready);
endinterface

### design/xxhash32_stream_hasher.sv
`timescale 1ns / 1ps
// Top level of the xxHash32 stream hasher: controller, datapath and ports.
// Depends on xxh_pkg, xxh_msg_if, xxh_digest_if, xxh_cfg_if, xxh_ctrl, xxh_datapath.
//
//  channel  dir  payload                          item
//  -------  ---  -------------------------------  -------------------------------
//  msg      in   byte_value, byte_present, last   one message byte (or none)
//  digest   out  hash_value, message_length       one digest per closed message
//  cfg      in   seed                             seed write, always ready
//
// Steps: a byte item is one accept step; the byte that completes a 16-byte stripe adds
//   a lane round per lane (multiply, add/rotate, multiply).
// Close: 1 merge-select + 3 lane merge adds (only if a stripe was seen) + 1 length
//   add, then a tail check with a multiply, add/rotate, multiply round per tail word
//   and per tail byte, a last tail check, 2 avalanche multiplies and 1 emit. Each
//   round and tail step is split so that it uses the one shared 32x32 multiplier once.
// Reset: rst is synchronous, active high; clears seed, counters, flags and the
//   result valid. No clearing pass is needed.
// Stalls: a waiting digest does not block new bytes; only the write of the next
//   digest waits for the result register to drain.
module xxhash32_stream_hasher (
  input  logic           clk,
  input  logic           rst,
  xxh_msg_if.sink        msg,
  xxh_digest_if.source   digest,
  xxh_cfg_if.sink        cfg
);

  xxh_pkg::cmd_t cmd;
  xxh_pkg::sts_t sts;

  // seed writes go straight into the seed register, so the config port never stalls
  assign cfg.ready = 1'b1;

  xxh_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (msg.valid),
    .in_present (msg.byte_present),
    .in_last    (msg.last),
    .in_ready   (msg.ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  xxh_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_we       (cfg.valid),
    .cfg_seed     (cfg.seed),
    .byte_value   (msg.byte_value),
    .byte_present (msg.byte_present),
    .out_valid    (digest.valid),
    .out_ready    (digest.ready),
    .out_hash     (digest.hash_value),
    .out_len      (digest.message_length)
  );

  // a digest only appears after the emit step
  a_digest_from_emit : assert property (@(posedge clk) disable iff (rst)
    $rose(digest.valid) |-> $past(cmd.op == xxh_pkg::OP_EMIT))
    else $error("digest valid rose without an emit step");

  // a byte that completes a stripe starts the lane rounds next cycle
  a_stripe_starts_round : assert property (@(posedge clk) disable iff (rst)
    (msg.valid && msg.ready && msg.byte_present && sts.stripe_edge)
      |=> (cmd.op == xxh_pkg::OP_R_MUL))
    else $error("completed stripe did not start a lane round");

  // emit with a free result register always presents a digest
  a_emit_lands : assert property (@(posedge clk) disable iff (rst)
    (cmd.op == xxh_pkg::OP_EMIT && sts.out_free) |=> digest.valid)
    else $error("emit did not load the result register");

  // no item is taken while a step is in flight
  a_ready_only_idle : assert property (@(posedge clk) disable iff (rst)
    msg.ready |-> (cmd.op == xxh_pkg::OP_ACCEPT || cmd.op == xxh_pkg::OP_NONE))
    else $error("input ready during a datapath step");

endmodule

### design/xxh_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the xxHash32 hasher: accepts items, runs lane rounds and
// finalisation steps on the datapath. Depends on xxh_pkg.
module xxh_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_present,
  input  logic          in_last,
  output logic          in_ready,
  input  xxh_pkg::sts_t sts,
  output xxh_pkg::cmd_t cmd
);

  xxh_pkg::state_t state, state_next;
  logic            last_pend, last_pend_next;
  logic [1:0]      merge_k, merge_k_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= xxh_pkg::ST_IDLE;
      last_pend <= 1'b0;
      merge_k   <= '0;
    end else begin
      state     <= state_next;
      last_pend <= last_pend_next;
      merge_k   <= merge_k_next;
    end
  end

  always_comb begin
    state_next     = state;
    last_pend_next = last_pend;
    merge_k_next   = merge_k;
    in_ready       = 1'b0;
    cmd.op         = xxh_pkg::OP_NONE;
    cmd.merge_lane = merge_k;
    unique case (state)
      xxh_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op         = xxh_pkg::OP_ACCEPT;
          last_pend_next = in_last;
          merge_k_next   = 2'd0;
          if (in_present && sts.stripe_edge) state_next = xxh_pkg::ST_R_MUL;
          else if (in_last)                  state_next = xxh_pkg::ST_MERGE0;
        end
      end
      xxh_pkg::ST_R_MUL: begin
        cmd.op     = xxh_pkg::OP_R_MUL;
        state_next = xxh_pkg::ST_R_ROT;
      end
      xxh_pkg::ST_R_ROT: begin
        cmd.op     = xxh_pkg::OP_R_ROT;
        state_next = xxh_pkg::ST_R_FIN;
      end
      xxh_pkg::ST_R_FIN: begin
        cmd.op       = xxh_pkg::OP_R_FIN;
        merge_k_next = merge_k + 2'd1;
        if (merge_k != 2'd3) state_next = xxh_pkg::ST_R_MUL;
        else state_next = last_pend ? xxh_pkg::ST_MERGE0 : xxh_pkg::ST_IDLE;
      end
      xxh_pkg::ST_MERGE0: begin
        cmd.op       = xxh_pkg::OP_MERGE_FIRST;
        merge_k_next = 2'd1;
        state_next   = sts.seen ? xxh_pkg::ST_MERGE : xxh_pkg::ST_ADD_LEN;
      end
      xxh_pkg::ST_MERGE: begin
        cmd.op       = xxh_pkg::OP_MERGE_ADD;
        merge_k_next = merge_k + 2'd1;
        if (merge_k == 2'd3) state_next = xxh_pkg::ST_ADD_LEN;
      end
      xxh_pkg::ST_ADD_LEN: begin
        cmd.op     = xxh_pkg::OP_ADD_LEN;
        state_next = xxh_pkg::ST_TAIL;
      end
      xxh_pkg::ST_TAIL: begin
        priority if (sts.fill_ge4) state_next = xxh_pkg::ST_W_MUL;
        else if (sts.fill_nz)      state_next = xxh_pkg::ST_B_MUL;
        else                       state_next = xxh_pkg::ST_AV1;
      end
      xxh_pkg::ST_W_MUL: begin
        cmd.op     = xxh_pkg::OP_W_MUL;
        state_next = xxh_pkg::ST_W_ROT;
      end
      xxh_pkg::ST_W_ROT: begin
        cmd.op     = xxh_pkg::OP_W_ROT;
        state_next = xxh_pkg::ST_W_FIN;
      end
      xxh_pkg::ST_W_FIN: begin
        cmd.op     = xxh_pkg::OP_W_FIN;
        state_next = xxh_pkg::ST_TAIL;
      end
      xxh_pkg::ST_B_MUL: begin
        cmd.op     = xxh_pkg::OP_B_MUL;
        state_next = xxh_pkg::ST_B_ROT;
      end
      xxh_pkg::ST_B_ROT: begin
        cmd.op     = xxh_pkg::OP_B_ROT;
        state_next = xxh_pkg::ST_B_FIN;
      end
      xxh_pkg::ST_B_FIN: begin
        cmd.op     = xxh_pkg::OP_B_FIN;
        state_next = xxh_pkg::ST_TAIL;
      end
      xxh_pkg::ST_AV1: begin
        cmd.op     = xxh_pkg::OP_AV1;
        state_next = xxh_pkg::ST_AV2;
      end
      xxh_pkg::ST_AV2: begin
        cmd.op     = xxh_pkg::OP_AV2;
        state_next = xxh_pkg::ST_EMIT;
      end
      xxh_pkg::ST_EMIT: begin
        cmd.op = xxh_pkg::OP_EMIT;
        if (sts.out_free) state_next = xxh_pkg::ST_IDLE;
      end
      default: state_next = xxh_pkg::ST_IDLE;
    endcase
  end

endmodule

### design/xxh_datapath.sv
`timescale 1ns / 1ps
// Datapath of the xxHash32 hasher: lanes, stripe buffer, counters, one shared
// 32x32 multiplier and the result register. Depends on xxh_pkg.
module xxh_datapath (
  input  logic          clk,
  input  logic          rst,
  input  xxh_pkg::cmd_t cmd,
  output xxh_pkg::sts_t sts,
  input  logic          cfg_we,
  input  logic [31:0]   cfg_seed,
  input  logic [7:0]    byte_value,
  input  logic          byte_present,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [31:0]   out_hash,
  output logic [31:0]   out_len
);

  logic [31:0] seed;
  logic [31:0] msg_seed;
  logic [31:0] lane [xxh_pkg::LANES];
  logic [7:0]  buf_b [xxh_pkg::STRIPE_BYTES];
  logic [3:0]  fill;
  logic [31:0] len;
  logic        msg_open;
  logic        seen;
  logic [31:0] t;
  logic [31:0] h;

  logic [31:0] mul_a, mul_k, prod;
  logic [1:0]  rd_idx;
  logic [31:0] lane_rd, merge_rot;
  logic [31:0] stripe_word;                // LE word of the stripe for the lane in hand
  logic        emit_go;

  assign rd_idx  = cmd.merge_lane;
  assign lane_rd = lane[rd_idx];

  always_comb begin
    unique case (rd_idx)
      2'd0: merge_rot = xxh_pkg::rotl32(lane_rd, 1);
      2'd1: merge_rot = xxh_pkg::rotl32(lane_rd, 7);
      2'd2: merge_rot = xxh_pkg::rotl32(lane_rd, 12);
      2'd3: merge_rot = xxh_pkg::rotl32(lane_rd, 18);
      default: merge_rot = lane_rd;
    endcase
  end

  always_comb begin
    unique case (rd_idx)
      2'd0:    stripe_word = {buf_b[3], buf_b[2], buf_b[1], buf_b[0]};
      2'd1:    stripe_word = {buf_b[7], buf_b[6], buf_b[5], buf_b[4]};
      2'd2:    stripe_word = {buf_b[11], buf_b[10], buf_b[9], buf_b[8]};
      default: stripe_word = {buf_b[15], buf_b[14], buf_b[13], buf_b[12]};
    endcase
  end

  always_comb begin
    mul_a = h;
    mul_k = xxh_pkg::PRIME1;
    unique case (cmd.op)
      xxh_pkg::OP_R_MUL: begin mul_a = stripe_word; mul_k = xxh_pkg::PRIME2; end
      xxh_pkg::OP_R_FIN: begin mul_a = t;   mul_k = xxh_pkg::PRIME1; end
      xxh_pkg::OP_W_MUL: begin
        mul_a = {buf_b[3], buf_b[2], buf_b[1], buf_b[0]};
        mul_k = xxh_pkg::PRIME3;
      end
      xxh_pkg::OP_W_FIN: mul_k = xxh_pkg::PRIME4;
      xxh_pkg::OP_B_MUL: begin mul_a = {24'd0, buf_b[0]}; mul_k = xxh_pkg::PRIME5; end
      xxh_pkg::OP_B_FIN: mul_k = xxh_pkg::PRIME1;
      xxh_pkg::OP_AV1:   begin mul_a = h ^ (h >> 15); mul_k = xxh_pkg::PRIME2; end
      xxh_pkg::OP_AV2:   begin mul_a = h ^ (h >> 13); mul_k = xxh_pkg::PRIME3; end
      default: ;
    endcase
  end

  assign prod = mul_a * mul_k;

  assign emit_go = (cmd.op == xxh_pkg::OP_EMIT) && sts.out_free;

  assign sts.stripe_edge = (fill == 4'd15);
  assign sts.seen        = seen;
  assign sts.fill_ge4    = (fill[3:2] != 2'b00);
  assign sts.fill_nz     = (fill != 4'd0);
  assign sts.out_free    = !out_valid || out_ready;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      seed      <= '0;
      fill      <= '0;
      len       <= '0;
      msg_open  <= 1'b0;
      seen      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) seed <= cfg_seed;
      if (emit_go)                     out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (cmd.op)
        xxh_pkg::OP_ACCEPT: begin
          msg_open <= 1'b1;
          if (byte_present) begin
            fill <= fill + 4'd1;
            len  <= len + 32'd1;
            if (fill == 4'd15) seen <= 1'b1;
          end
        end
        xxh_pkg::OP_W_FIN: fill <= fill - 4'd4;
        xxh_pkg::OP_B_FIN: fill <= fill - 4'd1;
        xxh_pkg::OP_EMIT: begin
          if (emit_go) begin
            fill      <= '0;
            len       <= '0;
            msg_open  <= 1'b0;
            seen      <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      xxh_pkg::OP_ACCEPT: begin
        if (!msg_open) begin
          msg_seed <= seed;
          lane[0]  <= seed + xxh_pkg::PRIME1 + xxh_pkg::PRIME2;
          lane[1]  <= seed + xxh_pkg::PRIME2;
          lane[2]  <= seed;
          lane[3]  <= seed - xxh_pkg::PRIME1;
        end
        if (byte_present) buf_b[fill] <= byte_value;
      end
      xxh_pkg::OP_R_MUL:       t <= prod;
      xxh_pkg::OP_R_ROT:       t <= xxh_pkg::rotl32(lane_rd + t, 13);
      xxh_pkg::OP_R_FIN:       lane[rd_idx] <= prod;
      xxh_pkg::OP_MERGE_FIRST: h <= seen ? merge_rot : msg_seed + xxh_pkg::PRIME5;
      xxh_pkg::OP_MERGE_ADD:   h <= h + merge_rot;
      xxh_pkg::OP_ADD_LEN:     h <= h + len;
      xxh_pkg::OP_W_MUL:       t <= prod;
      xxh_pkg::OP_W_ROT:       h <= xxh_pkg::rotl32(h + t, 17);
      xxh_pkg::OP_W_FIN: begin
        h <= prod;
        for (int i = 0; i < 12; i++) buf_b[i] <= buf_b[i + 4];
      end
      xxh_pkg::OP_B_MUL:       t <= prod;
      xxh_pkg::OP_B_ROT:       h <= xxh_pkg::rotl32(h + t, 11);
      xxh_pkg::OP_B_FIN: begin
        h <= prod;
        for (int i = 0; i < 15; i++) buf_b[i] <= buf_b[i + 1];
      end
      xxh_pkg::OP_AV1:         h <= prod;
      xxh_pkg::OP_AV2:         h <= prod;
      xxh_pkg::OP_EMIT: begin
        if (emit_go) begin
          out_hash <= h ^ (h >> 16);
          out_len  <= len;
        end
      end
      default: ;
    endcase
  end

endmodule

### tb/xxh_digest_checker.sv
`timescale 1ns / 1ps
// Digest checker for the xxHash32 stream hasher: watches the seed, message and
// digest channels, predicts each digest and compares it field by field.
// Depends on xxh_pkg, xxh_msg_if, xxh_digest_if and xxh_cfg_if.
module xxh_digest_checker (
  input  logic        clk,
  input  logic        rst,
  xxh_msg_if          msg,
  xxh_digest_if       digest,
  xxh_cfg_if          cfg,
  output int unsigned errors,
  output int unsigned outstanding,
  output int unsigned digests_checked
);

  typedef struct packed {
    logic [31:0] hash_value;
    logic [31:0] message_length;
  } digest_t;

  digest_t     pending_digests[$];
  logic [31:0] seed_reg;
  logic [31:0] msg_seed;
  logic [31:0] byte_count;
  logic [31:0] lane [xxh_pkg::LANES];
  logic [7:0]  stripe [xxh_pkg::STRIPE_BYTES];
  int unsigned fill;
  bit          msg_open;
  bit          stripe_seen;

  function automatic logic [31:0] rot_left(input logic [31:0] x, input int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // little-endian word from the stripe store
  function automatic logic [31:0] le_word(input int unsigned i);
    return {stripe[i + 3], stripe[i + 2], stripe[i + 1], stripe[i]};
  endfunction

  function automatic logic [31:0] lane_round(input logic [31:0] acc, input logic [31:0] w);
    logic [31:0] a;
    a = acc + w * xxh_pkg::PRIME2;
    a = rot_left(a, 13);
    return a * xxh_pkg::PRIME1;
  endfunction

  function automatic logic [31:0] avalanche(input logic [31:0] x);
    logic [31:0] h;
    h = x;
    h ^= h >> 15;
    h *= xxh_pkg::PRIME2;
    h ^= h >> 13;
    h *= xxh_pkg::PRIME3;
    h ^= h >> 16;
    return h;
  endfunction

  task automatic absorb_item(input logic [7:0] value, input logic present, input logic closes);
    logic [31:0] h;
    int unsigned i;
    int unsigned k;
    // first item of a message latches the seed, whatever it carries
    if (!msg_open) begin
      msg_open = 1'b1;
      msg_seed = seed_reg;
      lane[0]  = msg_seed + xxh_pkg::PRIME1 + xxh_pkg::PRIME2;
      lane[1]  = msg_seed + xxh_pkg::PRIME2;
      lane[2]  = msg_seed;
      lane[3]  = msg_seed - xxh_pkg::PRIME1;
    end
    if (present) begin
      stripe[fill] = value;
      fill++;
      byte_count++;
      if (fill == xxh_pkg::STRIPE_BYTES) begin
        for (k = 0; k < xxh_pkg::LANES; k++) lane[k] = lane_round(lane[k], le_word(4 * k));
        fill        = 0;
        stripe_seen = 1'b1;
      end
    end
    if (closes) begin
      if (stripe_seen) begin
        h = rot_left(lane[0], 1) + rot_left(lane[1], 7)
          + rot_left(lane[2], 12) + rot_left(lane[3], 18);
      end else begin
        h = msg_seed + xxh_pkg::PRIME5;
      end
      h += byte_count;
      i = 0;
      while (i + 4 <= fill) begin
        h += le_word(i) * xxh_pkg::PRIME3;
        h = rot_left(h, 17) * xxh_pkg::PRIME4;
        i += 4;
      end
      while (i < fill) begin
        h += {24'd0, stripe[i]} * xxh_pkg::PRIME5;
        h = rot_left(h, 11) * xxh_pkg::PRIME1;
        i++;
      end
      pending_digests.push_back('{avalanche(h), byte_count});
      fill        = 0;
      byte_count  = 0;
      msg_open    = 1'b0;
      stripe_seen = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    digest_t got;
    digest_t want;
    if (rst) begin
      pending_digests.delete();
      seed_reg        = '0;
      msg_seed        = '0;
      byte_count      = '0;
      fill            = 0;
      msg_open        = 1'b0;
      stripe_seen     = 1'b0;
      errors          = 0;
      outstanding     = 0;
      digests_checked = 0;
    end else begin
      if (digest.valid && digest.ready) begin
        got = '{digest.hash_value, digest.message_length};
        digests_checked++;
        if (pending_digests.size() == 0) begin
          errors++;
          $display("%0t: unexpected digest, expected none, got hash %08h length %0d",
                   $time, got.hash_value, got.message_length);
        end else begin
          want = pending_digests.pop_front();
          if (got.hash_value !== want.hash_value) begin
            errors++;
            $display("%0t: hash_value expected %08h, got %08h",
                     $time, want.hash_value, got.hash_value);
          end
          if (got.message_length !== want.message_length) begin
            errors++;
            $display("%0t: message_length expected %0d, got %0d",
                     $time, want.message_length, got.message_length);
          end
        end
      end
      if (msg.valid && msg.ready) absorb_item(msg.byte_value, msg.byte_present, msg.last);
      if (cfg.valid && cfg.ready) seed_reg = cfg.seed;
      outstanding = pending_digests.size();
    end
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// Top of the xxHash32 stream hasher testbench: clock, reset, seed writes,
// message stimulus and digest back-pressure; checking sits in xxh_digest_checker.
// Depends on xxh_pkg, the channel interfaces, xxhash32_stream_hasher, xxh_digest_checker.
module testbench;

  localparam int unsigned CYCLE_LIMIT  = 500000;  // watchdog bound on the whole run
  localparam int unsigned DRAIN_CYCLES = 64;      // longest close plus a lane round in flight
  localparam int unsigned LONG_HOLD    = 400;     // output hold-off to back the block up

  logic clk;
  logic rst;

  xxh_msg_if    msg_ch ();
  xxh_digest_if digest_ch ();
  xxh_cfg_if    cfg_ch ();

  int unsigned fail_count;
  int unsigned expect_count;
  int unsigned digest_count;

  // idle pattern per side: 0 = back to back, 1 = a random gap before every item, 2 = mostly back to back
  int unsigned src_mode     = 1;
  int unsigned sink_mode    = 1;
  bit          hold_request = 1'b0;
  int unsigned items_sent    = 0;
  int unsigned messages_sent = 0;
  int unsigned cycle_count   = 0;

  xxhash32_stream_hasher dut (
    .clk    (clk),
    .rst    (rst),
    .msg    (msg_ch),
    .digest (digest_ch),
    .cfg    (cfg_ch)
  );

  xxh_digest_checker u_digest_check (
    .clk             (clk),
    .rst             (rst),
    .msg             (msg_ch),
    .digest          (digest_ch),
    .cfg             (cfg_ch),
    .errors          (fail_count),
    .outstanding     (expect_count),
    .digests_checked (digest_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached with %0d digests outstanding", $time, expect_count);
      $display("testbench: done, errors");
      $finish;
    end
  end

  function automatic int unsigned draw_gap(input int unsigned mode);
    if (mode == 0) return 0;
    if (mode == 1) return $urandom_range(0, 18);
    return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
  endfunction

  // Mostly short messages, a fair share spanning one to three stripes, a few long.
  function automatic int unsigned random_length();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return $urandom_range(0, 20);
    if (pick < 9) return $urandom_range(21, 48);
    return $urandom_range(49, 100);
  endfunction

  // One item on the message channel. valid is only dropped when a gap follows,
  // so back-to-back items never see valid lowered and raised in one step.
  task automatic send_item(input logic [7:0] value, input logic present, input logic closes);
    int unsigned gap;
    gap = draw_gap(src_mode);
    if (gap != 0) begin
      msg_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    msg_ch.valid        <= 1'b1;
    msg_ch.byte_value   <= value;
    msg_ch.byte_present <= present;
    msg_ch.last         <= closes;
    @(posedge clk);
    while (!msg_ch.ready) @(posedge clk);
    items_sent++;
    if (closes) messages_sent++;
  endtask

  // Random bytes, now and then an empty item inside; the close rides on the
  // final byte or on a trailing item with no byte.
  task automatic send_message(input int unsigned len);
    int unsigned n;
    bit          tail_close;
    tail_close = (len == 0) || ($urandom_range(0, 3) == 0);
    for (n = 0; n < len; n++) begin
      if ($urandom_range(0, 11) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, !tail_close && (n == len - 1));
    end
    if (tail_close) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic random_messages(input int unsigned target);
    while (items_sent < target) begin
      src_mode  = $urandom_range(0, 2);
      sink_mode = $urandom_range(0, 2);
      send_message(random_length());
    end
  endtask

  // Drop valid, let every expected digest come out, then allow for a close
  // still running on the datapath.
  task automatic settle();
    msg_ch.valid <= 1'b0;
    @(posedge clk);
    while (expect_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed(input logic [31:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.seed  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Digest side: random stall per item, one long hold-off on request.
  initial begin : digest_sink
    int unsigned stall;
    digest_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        stall        = LONG_HOLD;
      end else begin
        stall = draw_gap(sink_mode);
      end
      if (stall != 0) begin
        digest_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      digest_ch.ready <= 1'b1;
      @(posedge clk);
      while (!digest_ch.valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    int unsigned n;
    rst                 <= 1'b1;
    msg_ch.valid        <= 1'b0;
    msg_ch.byte_value   <= 8'h00;
    msg_ch.byte_present <= 1'b0;
    msg_ch.last         <= 1'b0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.seed         <= 32'h0000_0000;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part on the reset seed of zero.
    send_item(8'h00, 1'b0, 1'b1);          // empty message
    send_item(8'hFF, 1'b1, 1'b1);          // single byte, all ones
    send_item(8'h00, 1'b0, 1'b0);          // empty item opens the message
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'h5A, 1'b0, 1'b0);          // empty item mid-message: no effect
    send_item(8'hA5, 1'b0, 1'b1);          // close on an item with no byte
    for (n = 1; n < 16; n++) send_item(8'(n), 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b1);          // exactly one stripe, empty tail
    settle();

    write_seed(32'hFFFF_FFFF);
    random_messages(250);
    settle();

    // Seed changed after the message has opened: the old seed must still apply.
    write_seed(32'h0000_0000);
    src_mode = 2;
    send_item(8'h3C, 1'b0, 1'b0);
    settle();
    write_seed(32'($urandom));
    send_message(21);
    random_messages(450);
    settle();

    // Back-pressure: output held off while short messages arrive back to back,
    // so the result register fills and the input stalls.
    write_seed(32'($urandom));
    src_mode     = 0;
    sink_mode    = 0;
    hold_request = 1'b1;
    repeat (40) send_message($urandom_range(0, 3));
    settle();

    write_seed(32'h0000_0001);
    random_messages(750);
    settle();

    write_seed(32'h8000_0000);
    random_messages(1050);
    settle();

    $display("run summary: %0d items in %0d messages, %0d digests compared",
             items_sent, messages_sent, digest_count);
    $display("run summary: seeds zero, all ones, one, top bit and random; mid-message seed %s",
             "write; long output hold-off");
    if (expect_count != 0) $display("%0t: %0d digests never arrived", $time, expect_count);
    if (fail_count == 0 && expect_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
